[hdl/lsfe_pkg.sv]
package lsfe_pkg;

  localparam int LSFE_MAX_LEDS = 256;
  localparam int ROW_BYTES     = 9;
  localparam int CFG_DATA_W    = 9;
  localparam int CFG_IDX_W     = 2;

  localparam logic [8:0] LED_COUNT_RST  = 9'd256;
  localparam logic [3:0] FRONT_ROWS_RST = 4'd3;
  localparam logic [3:0] REAR_ROWS_RST  = 4'd3;

  localparam logic [2:0] SYM_ONE  = 3'b110;
  localparam logic [2:0] SYM_ZERO = 3'b100;

  localparam logic [3:0] LAST_BYTE = 4'(ROW_BYTES - 1);

  typedef enum logic [1:0] {
    CFG_LED_COUNT  = 2'd0,
    CFG_FRONT_ROWS = 2'd1,
    CFG_REAR_ROWS  = 2'd2
  } cfg_idx_t;

  typedef enum logic {
    REQ_WRITE = 1'b0,
    REQ_EMIT  = 1'b1
  } req_type_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SEND
  } state_t;

  typedef struct packed {
    logic [8:0] led_count;
    logic [3:0] front_rows;
    logic [3:0] rear_rows;
  } cfg_t;

  // Each colour bit becomes a three-bit symbol, MSB first.
  function automatic logic [23:0] expand_colour(input logic [7:0] c);
    logic [23:0] w;
    w = '0;
    for (int i = 0; i < 8; i++) begin
      w[3*i +: 3] = c[i] ? SYM_ONE : SYM_ZERO;
    end
    return w;
  endfunction

  // Byte k of an LED row: green bytes 0-2, red 3-5, blue 6-8.
  function automatic logic [7:0] row_byte(input logic [23:0] px, input logic [3:0] k);
    logic [7:0]  c;
    logic [23:0] w;
    case (k)
      4'd0, 4'd1, 4'd2: c = px[23:16];
      4'd3, 4'd4, 4'd5: c = px[15:8];
      default:          c = px[7:0];
    endcase
    w = expand_colour(c);
    case (k)
      4'd0, 4'd3, 4'd6: return w[23:16];
      4'd1, 4'd4, 4'd7: return w[15:8];
      default:          return w[7:0];
    endcase
  endfunction

endpackage

[hdl/lsfe_req_if.sv]
interface lsfe_req_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] led_index;
  logic [7:0] green;
  logic [7:0] red;
  logic [7:0] blue;

  modport source (output valid, req_type, led_index, green, red, blue, input ready);
  modport sink   (input valid, req_type, led_index, green, red, blue, output ready);
endinterface

[hdl/lsfe_byte_if.sv]
interface lsfe_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] spi_byte;
  logic       row_last;
  logic       frame_last;

  modport source (output valid, spi_byte, row_last, frame_last, input ready);
  modport sink   (input valid, spi_byte, row_last, frame_last, output ready);
endinterface

[hdl/lsfe_cfg_regs.sv]
module lsfe_cfg_regs
  import lsfe_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.led_count  <= LED_COUNT_RST;
      cfg.front_rows <= FRONT_ROWS_RST;
      cfg.rear_rows  <= REAR_ROWS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_LED_COUNT:  cfg.led_count  <= cfg_data;
        CFG_FRONT_ROWS: cfg.front_rows <= cfg_data[3:0];
        CFG_REAR_ROWS:  cfg.rear_rows  <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

endmodule

[hdl/lsfe_pixel_ram.sv]
module lsfe_pixel_ram
  import lsfe_pkg::*;
#(
  parameter int MAX_LEDS = LSFE_MAX_LEDS,
  parameter int AW       = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [23:0]   wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [23:0]   rdata
);

  logic [23:0] mem [MAX_LEDS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hdl/lsfe_frame_ctrl.sv]
module lsfe_frame_ctrl
  import lsfe_pkg::*;
#(
  parameter int MAX_LEDS = LSFE_MAX_LEDS,
  parameter int AW       = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1
) (
  input  logic          clk,
  input  logic          rst,
  input  cfg_t          cfg,
  lsfe_req_if.sink      req,
  lsfe_byte_if.source   spi_out,
  output logic          ram_we,
  output logic [AW-1:0] ram_waddr,
  output logic [23:0]   ram_wdata,
  output logic          ram_re,
  output logic [AW-1:0] ram_raddr,
  input  logic [23:0]   ram_rdata
);

  localparam int RW  = $clog2(MAX_LEDS + 31);
  localparam int CW  = ((RW > 9) ? RW : 9) + 1;
  localparam int IXW = AW + 8;

  state_t          state, state_next;
  logic [AW-1:0]   clr_addr;
  logic [RW-1:0]   row_pos;
  logic [3:0]      byte_cnt;
  logic            is_led;
  logic            last_row;

  logic [CW-1:0]   leds, total, row_eff, led_off;
  logic            led_row, last_row_now;
  logic            acc, emit_acc, out_xfer, clr_done, idx_ok;
  logic [IXW-1:0]  idx_wide;

  // Frame geometry from the live registers
  always_comb begin
    if (cfg.led_count == '0) begin
      leds = CW'(1);
    end else if (CW'(cfg.led_count) > CW'(MAX_LEDS)) begin
      leds = CW'(MAX_LEDS);
    end else begin
      leds = CW'(cfg.led_count);
    end
    total        = CW'(cfg.front_rows) + leds + CW'(cfg.rear_rows);
    row_eff      = (CW'(row_pos) >= total) ? '0 : CW'(row_pos);
    led_row      = (row_eff >= CW'(cfg.front_rows)) &&
                   (row_eff < CW'(cfg.front_rows) + leds);
    last_row_now = (row_eff + CW'(1) == total);
    led_off      = row_eff - CW'(cfg.front_rows);
  end

  assign clr_done = (clr_addr == AW'(MAX_LEDS - 1));
  assign out_xfer = spi_out.valid && spi_out.ready;
  assign req.ready = (state == ST_IDLE) ||
                     ((state == ST_SEND) && (byte_cnt == LAST_BYTE) && spi_out.ready);
  assign acc      = req.valid && req.ready;
  assign emit_acc = acc && (req.req_type == REQ_EMIT);

  assign idx_wide = IXW'(req.led_index);
  assign idx_ok   = (32'(req.led_index) < 32'(MAX_LEDS));

  // Memory port: clearing pass after reset, else stores and row fetches
  assign ram_we    = (state == ST_CLEAR) || (acc && (req.req_type == REQ_WRITE) && idx_ok);
  assign ram_waddr = (state == ST_CLEAR) ? clr_addr : idx_wide[AW-1:0];
  assign ram_wdata = (state == ST_CLEAR) ? 24'd0 : {req.green, req.red, req.blue};
  assign ram_re    = emit_acc;
  assign ram_raddr = led_off[AW-1:0];

  assign spi_out.valid      = (state == ST_SEND);
  assign spi_out.spi_byte   = is_led ? row_byte(ram_rdata, byte_cnt) : 8'd0;
  assign spi_out.row_last   = (byte_cnt == LAST_BYTE);
  assign spi_out.frame_last = (byte_cnt == LAST_BYTE) && last_row;

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: if (clr_done) state_next = ST_IDLE;
      ST_IDLE:  if (emit_acc) state_next = ST_SEND;
      ST_SEND: begin
        if (out_xfer && (byte_cnt == LAST_BYTE)) begin
          state_next = emit_acc ? ST_SEND : ST_IDLE;
        end
      end
      default:  state_next = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
      row_pos  <= '0;
      byte_cnt <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + AW'(1);
      end
      if (emit_acc) begin
        row_pos  <= last_row_now ? '0 : RW'(row_eff + CW'(1));
        byte_cnt <= '0;
      end else if (out_xfer) begin
        byte_cnt <= byte_cnt + 4'd1;
      end
    end
  end

  // Row flags travel with the fetched pixel
  always_ff @(posedge clk) begin
    if (emit_acc) begin
      is_led   <= led_row;
      last_row <= last_row_now;
    end
  end

`ifndef ASSERT_OFF
  a_emit_starts_row: assert property (@(posedge clk) disable iff (rst)
    emit_acc |=> (spi_out.valid && (byte_cnt == 4'd0)))
    else $error("emit transfer not followed by first byte of row");

  a_frame_in_row: assert property (@(posedge clk) disable iff (rst)
    (spi_out.valid && spi_out.frame_last) |-> spi_out.row_last)
    else $error("frame_last outside the last byte of a row");

  a_row_end: assert property (@(posedge clk) disable iff (rst)
    (out_xfer && spi_out.row_last) |=> (!spi_out.valid || $past(emit_acc)))
    else $error("bytes sent past the end of a row");

  a_no_req_in_clear: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR) |-> (!acc && ram_we && !ram_re))
    else $error("item taken while pixel memory is clearing");

  a_row_in_frame: assert property (@(posedge clk) disable iff (rst)
    emit_acc |=> (CW'(row_pos) < $past(total)))
    else $error("row counter left outside the frame");
`endif

endmodule

[hdl/addressable_led_spi_frame_encoder_top.sv]
// Emit: first SPI byte valid in the cycle after the emit transfer, then one byte per
// cycle while spi_out.ready holds; the next item is taken on the ninth byte's transfer.
// Write: taken whenever the request port is ready, no result.
// The pixel memory's registered read port fetches one LED word per emit.
// Reset: registers to their defaults, row counter to zero, then a clearing pass writes
// black to every LED; configuration writes are taken meanwhile.
module addressable_led_spi_frame_encoder_top
  import lsfe_pkg::*;
#(
  parameter int MAX_LEDS = LSFE_MAX_LEDS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  lsfe_req_if.sink              req,
  lsfe_byte_if.source           spi_out
);

  localparam int AW = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;

  cfg_t          cfg;
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [23:0]   ram_wdata, ram_rdata;

  lsfe_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  lsfe_pixel_ram #(.MAX_LEDS(MAX_LEDS), .AW(AW)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  lsfe_frame_ctrl #(.MAX_LEDS(MAX_LEDS), .AW(AW)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .req       (req),
    .spi_out   (spi_out),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

endmodule
